@@ hdl/rcq_pkg.sv @@
// shared types and constants for the reversible circular queue
package rcq_pkg;

  localparam int WORD_W = 32;

  // request kinds
  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REV = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // word returned by a dequeue from an empty queue
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // one request
  typedef struct packed {
    logic [1:0]               operation;
    logic signed [WORD_W-1:0] value_in;
  } req_t;

  // one result
  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic [1:0]               status;
  } rsp_t;

  // result control passed from the queue controller to the output stage
  typedef struct packed {
    logic    valid;
    logic    from_ram;
    logic    neg_one;
    status_e status;
  } rcq_meta_t;

endpackage

@@ hdl/rcq_ram.sv @@
// generic single-port ram with registered read
module rcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/rcq_ctrl.sv @@
// head, count and direction control of the queue plus memory access issue
module rcq_ctrl import rcq_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int CW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  req_t              req,
  output logic              ram_we,
  output logic [AW-1:0]     ram_addr,
  output logic [WORD_W-1:0] ram_wdata,
  output rcq_meta_t         meta
);

  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          rev;
  logic          rev_next;
  rcq_meta_t     meta_next;

  logic          full;
  logic          empty;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_free;   // slot after the logical back, normal direction
  logic [AW-1:0] tail_last;   // slot of the logical back, normal direction
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  // slot arithmetic modulo depth, one compare and subtract each
  always_comb begin
    tail_sum  = (AW+1)'(head) + (AW+1)'(count);
    tail_free = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
    tail_last = (tail_sum - 1'b1 >= DEPTH_W) ? AW'(tail_sum - 1'b1 - DEPTH_W)
                                              : AW'(tail_sum - 1'b1);
    head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
    head_dec  = (head == '0) ? LAST_IDX : head - 1'b1;
  end

  // request decode and next state
  always_comb begin
    head_next       = head;
    count_next      = count;
    rev_next        = rev;
    ram_we          = 1'b0;
    ram_addr        = head;
    ram_wdata       = req.value_in;
    meta_next       = '0;
    meta_next.valid = accept;
    if (accept) begin
      case (req.operation)
        OP_ENQ: begin
          if (full) begin
            meta_next.status = ST_FULL;
          end else begin
            ram_we     = 1'b1;
            ram_addr   = rev ? head_dec : tail_free;
            head_next  = rev ? head_dec : head;
            count_next = count + 1'b1;
          end
        end
        OP_DEQ: begin
          if (empty) begin
            meta_next.status  = ST_EMPTY;
            meta_next.neg_one = 1'b1;
          end else begin
            meta_next.from_ram = 1'b1;
            ram_addr           = rev ? tail_last : head;
            head_next          = rev ? head : head_inc;
            count_next         = count - 1'b1;
          end
        end
        OP_REV: begin
          if (empty) begin
            meta_next.status = ST_EMPTY;
          end else begin
            rev_next = ~rev;
          end
        end
        default: begin
          meta_next.status = ST_DONE;
        end
      endcase
    end
  end

  // state and result control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
      meta  <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
      meta  <= meta_next;
    end
  end

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count above depth");

  // every accepted request gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> meta.valid)
    else $error("request without result");

  // successful enqueue grows the count by one
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_ENQ && !full) |=> count == $past(count) + 1'b1)
    else $error("enqueue did not grow count");

  // dequeue or reverse on an empty queue reports empty
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (req.operation == OP_DEQ || req.operation == OP_REV))
      |=> meta.status == ST_EMPTY)
    else $error("empty queue request reported wrong status");

endmodule

@@ hdl/reversible_circular_queue_unit.sv @@
// A result appears with done in the cycle after its request is accepted.
// Throughput: one request per cycle; busy stays low, each request touches one
// memory word through the single port of the storage ram.
// The receiver cannot stall: done is a one-cycle strobe with the result.
// Reset: synchronous rst empties the queue, clears direction and drops done;
// storage contents are left as they are and are never read before written.
module reversible_circular_queue_unit import rcq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  rcq_meta_t         meta;

  // a request is taken in every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rcq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .meta      (meta)
  );

  rcq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result assembly
  always_comb begin
    done   = meta.valid;
    rsp.status = meta.status;
    if (meta.from_ram) begin
      rsp.value_out = ram_rdata;
    end else if (meta.neg_one) begin
      rsp.value_out = EMPTY_WORD;
    end else begin
      rsp.value_out = '0;
    end
  end

endmodule
